### hdl/rtflex_pkg.sv
// ---------------------------------------------------------------------------
// RTF lexer package
// Shared token kinds, lexer modes, state and token records, and the small
// character helper functions used by the lexer step logic.
// ---------------------------------------------------------------------------
package rtflex_pkg;

    // Default width of the control word parameter accumulator.
    localparam int PARAM_BITS_DEFAULT = 32;

    // Token kinds.
    localparam logic [3:0] K_GRP_START = 4'd0;
    localparam logic [3:0] K_GRP_END   = 4'd1;
    localparam logic [3:0] K_TEXT      = 4'd2;
    localparam logic [3:0] K_TEXT_END  = 4'd3;
    localparam logic [3:0] K_LETTER    = 4'd4;
    localparam logic [3:0] K_WORD_END  = 4'd5;
    localparam logic [3:0] K_SYMBOL    = 4'd6;
    localparam logic [3:0] K_HEX       = 4'd7;
    localparam logic [3:0] K_BIN       = 4'd8;
    localparam logic [3:0] K_BIN_END   = 4'd9;
    localparam logic [3:0] K_EOF       = 4'd10;

    // Characters with a special meaning.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // Largest binary run length.
    localparam logic [30:0] BIN_LEN_MAX = 31'h7FFF_FFFF;

    // Lexer modes, one-hot.
    typedef enum logic [9:0] {
        MODE_IDLE     = 10'b00_0000_0001,
        MODE_ESC      = 10'b00_0000_0010,
        MODE_WORD_BIN = 10'b00_0000_0100,
        MODE_WORD     = 10'b00_0000_1000,
        MODE_MINUS    = 10'b00_0001_0000,
        MODE_DIGITS   = 10'b00_0010_0000,
        MODE_HEX1     = 10'b00_0100_0000,
        MODE_HEX2     = 10'b00_1000_0000,
        MODE_BINDATA  = 10'b01_0000_0000,
        MODE_BINEND   = 10'b10_0000_0000
    } lex_mode_t;

    // Lexer state apart from the parameter accumulator.
    typedef struct packed {
        lex_mode_t   mode;
        logic        text_open;
        logic [1:0]  held;
        logic [1:0]  flush_idx;
        logic        dash_inject;
        logic        param_neg;
        logic        param_sat;
        logic [7:0]  hex_high;
        logic        hex_replay;
        logic [30:0] bin_rem;
    } lex_state_t;

    // One token element.
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  value;
        logic        has_param;
        logic [31:0] param_value;
        logic        param_overflow;
    } token_t;

    // Step control toward the handshake logic.
    typedef struct packed {
        logic emit;
        logic consume;
    } step_ctl_t;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (is_digit(b)) begin
            d = b - 8'h30;
            return {1'b1, d[3:0]};
        end
        else if ((b >= 8'h61) && (b <= 8'h66)) begin
            d = b - 8'h57;
            return {1'b1, d[3:0]};
        end
        else if ((b >= 8'h41) && (b <= 8'h46)) begin
            d = b - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

    // Letters of the word bin, by position.
    function automatic logic [7:0] bin_letter(input logic [1:0] idx);
        case (idx)
            2'd0:    return 8'h62;
            2'd1:    return 8'h69;
            default: return 8'h6E;
        endcase
    endfunction

endpackage

### hdl/rtflex_step.sv
// ---------------------------------------------------------------------------
// RTF lexer step
// Combinational next-state logic: for the current byte and lexer state it
// gives at most one token, the next state, and whether the byte is used up.
// ---------------------------------------------------------------------------
module rtflex_step #(
    parameter int PARAM_BITS = rtflex_pkg::PARAM_BITS_DEFAULT
) (
    input  rtflex_pkg::lex_state_t cur,
    input  logic [PARAM_BITS-1:0]  accum,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_data,
    output rtflex_pkg::lex_state_t nxt,
    output logic [PARAM_BITS-1:0]  accum_next,
    output rtflex_pkg::token_t     tok,
    output rtflex_pkg::step_ctl_t  ctl
);

    localparam int CW = (PARAM_BITS > 31) ? PARAM_BITS : 31;
    localparam logic [PARAM_BITS+3:0] PARAM_MAX =
        (PARAM_BITS+4)'((65'd1 << (PARAM_BITS - 1)) - 65'd1);

    logic [7:0]            b;
    logic                  eod;
    logic                  take;
    logic [7:0]            low;
    logic [3:0]            digit;
    logic [PARAM_BITS+3:0] prod;
    logic                  prod_over;
    logic [PARAM_BITS-1:0] signed_mag;
    logic [31:0]           pv32;
    logic [CW-1:0]         acc_w;
    logic [30:0]           bin_len;
    logic                  to_bin;
    logic                  flushing;
    logic [4:0]            hv_hi;
    logic [4:0]            hv_lo;

    // Operand selection and parameter arithmetic.
    always_comb
    begin
        b          = cur.hex_replay ? cur.hex_high : data_byte;
        eod        = end_of_data && !cur.hex_replay;
        low        = b | 8'h20;
        digit      = 4'(b - rtflex_pkg::CH_ZERO);
        prod       = ((PARAM_BITS+4)'(accum) << 3) + ((PARAM_BITS+4)'(accum) << 1)
                     + (PARAM_BITS+4)'(digit);
        prod_over  = cur.param_sat || (prod > PARAM_MAX);
        signed_mag = cur.param_neg ? (~accum + 1'b1) : accum;
        acc_w      = CW'(accum);
        bin_len    = (acc_w > CW'(rtflex_pkg::BIN_LEN_MAX)) ? rtflex_pkg::BIN_LEN_MAX
                                                             : acc_w[30:0];
        to_bin     = (cur.held == 2'd3) && !cur.param_neg && (|accum);
        flushing   = (cur.flush_idx != cur.held);
        hv_hi      = rtflex_pkg::hex_val(cur.hex_high);
        hv_lo      = rtflex_pkg::hex_val(b);
    end

    // Low 32 bits of the signed parameter.
    generate
        if (PARAM_BITS >= 32) begin : g_wide
            assign pv32 = signed_mag[31:0];
        end
        else begin : g_narrow
            assign pv32 = {{(32-PARAM_BITS){signed_mag[PARAM_BITS-1]}}, signed_mag};
        end
    endgenerate

    // One lexer step.
    always_comb
    begin
        nxt        = cur;
        accum_next = accum;
        tok        = '0;
        ctl.emit   = 1'b0;
        take       = 1'b0;

        if (cur.dash_inject) begin
            // A minus that did not start a parameter comes out as text.
            ctl.emit        = 1'b1;
            tok.kind        = rtflex_pkg::K_TEXT;
            tok.value       = rtflex_pkg::CH_MINUS;
            nxt.text_open   = 1'b1;
            nxt.dash_inject = 1'b0;
        end
        else if (cur.mode == rtflex_pkg::MODE_BINEND) begin
            ctl.emit = 1'b1;
            tok.kind = rtflex_pkg::K_BIN_END;
            nxt.mode = rtflex_pkg::MODE_IDLE;
            take     = 1'b1;
        end
        else if (eod) begin
            // End of stream: flush whatever is pending, then eof.
            case (cur.mode)
                rtflex_pkg::MODE_ESC:
                begin
                    ctl.emit      = 1'b1;
                    tok.kind      = rtflex_pkg::K_TEXT;
                    tok.value     = rtflex_pkg::CH_BSLASH;
                    nxt.text_open = 1'b1;
                    nxt.mode      = rtflex_pkg::MODE_IDLE;
                end
                rtflex_pkg::MODE_WORD_BIN, rtflex_pkg::MODE_WORD, rtflex_pkg::MODE_MINUS:
                begin
                    ctl.emit = 1'b1;
                    if (flushing) begin
                        tok.kind      = rtflex_pkg::K_LETTER;
                        tok.value     = rtflex_pkg::bin_letter(cur.flush_idx);
                        nxt.flush_idx = cur.flush_idx + 2'd1;
                    end
                    else begin
                        tok.kind        = rtflex_pkg::K_WORD_END;
                        nxt.held        = 2'd0;
                        nxt.flush_idx   = 2'd0;
                        nxt.dash_inject = (cur.mode == rtflex_pkg::MODE_MINUS);
                        nxt.mode        = rtflex_pkg::MODE_IDLE;
                    end
                end
                rtflex_pkg::MODE_DIGITS:
                begin
                    ctl.emit = 1'b1;
                    if (to_bin) begin
                        tok.kind = rtflex_pkg::K_BIN_END;
                        nxt.mode = rtflex_pkg::MODE_IDLE;
                    end
                    else if (flushing) begin
                        tok.kind      = rtflex_pkg::K_LETTER;
                        tok.value     = rtflex_pkg::bin_letter(cur.flush_idx);
                        nxt.flush_idx = cur.flush_idx + 2'd1;
                    end
                    else begin
                        tok.kind           = rtflex_pkg::K_WORD_END;
                        tok.has_param      = 1'b1;
                        tok.param_value    = pv32;
                        tok.param_overflow = cur.param_sat;
                        nxt.mode           = rtflex_pkg::MODE_IDLE;
                    end
                    if (to_bin || !flushing) begin
                        nxt.held      = 2'd0;
                        nxt.flush_idx = 2'd0;
                        nxt.param_neg = 1'b0;
                        nxt.param_sat = 1'b0;
                        accum_next    = '0;
                    end
                end
                rtflex_pkg::MODE_HEX1, rtflex_pkg::MODE_HEX2:
                begin
                    ctl.emit  = 1'b1;
                    tok.kind  = rtflex_pkg::K_SYMBOL;
                    tok.value = rtflex_pkg::CH_QUOTE;
                    nxt.mode  = rtflex_pkg::MODE_IDLE;
                end
                rtflex_pkg::MODE_BINDATA:
                begin
                    ctl.emit = 1'b1;
                    tok.kind = rtflex_pkg::K_BIN_END;
                    nxt.mode = rtflex_pkg::MODE_IDLE;
                end
                default:
                begin
                    ctl.emit = 1'b1;
                    if (cur.text_open) begin
                        tok.kind      = rtflex_pkg::K_TEXT_END;
                        nxt.text_open = 1'b0;
                    end
                    else begin
                        // Eof returns everything to the reset state.
                        tok.kind   = rtflex_pkg::K_EOF;
                        nxt        = '0;
                        nxt.mode   = rtflex_pkg::MODE_IDLE;
                        accum_next = '0;
                        take       = 1'b1;
                    end
                end
            endcase
        end
        else begin
            case (cur.mode)
                rtflex_pkg::MODE_ESC:
                begin
                    take = 1'b1;
                    if (rtflex_pkg::is_letter(b)) begin
                        nxt.flush_idx = 2'd0;
                        if (low == rtflex_pkg::bin_letter(2'd0)) begin
                            nxt.held = 2'd1;
                            nxt.mode = rtflex_pkg::MODE_WORD_BIN;
                        end
                        else begin
                            nxt.held  = 2'd0;
                            ctl.emit  = 1'b1;
                            tok.kind  = rtflex_pkg::K_LETTER;
                            tok.value = low;
                            nxt.mode  = rtflex_pkg::MODE_WORD;
                        end
                    end
                    else if (b == rtflex_pkg::CH_QUOTE) begin
                        nxt.mode = rtflex_pkg::MODE_HEX1;
                    end
                    else begin
                        ctl.emit  = 1'b1;
                        tok.kind  = rtflex_pkg::K_SYMBOL;
                        tok.value = b;
                        nxt.mode  = rtflex_pkg::MODE_IDLE;
                    end
                end
                rtflex_pkg::MODE_WORD_BIN, rtflex_pkg::MODE_WORD:
                begin
                    if (rtflex_pkg::is_letter(b)) begin
                        if ((cur.mode == rtflex_pkg::MODE_WORD_BIN) && (cur.held != 2'd3)
                            && (low == rtflex_pkg::bin_letter(cur.held))) begin
                            nxt.held = cur.held + 2'd1;
                            take     = 1'b1;
                        end
                        else if (flushing) begin
                            ctl.emit      = 1'b1;
                            tok.kind      = rtflex_pkg::K_LETTER;
                            tok.value     = rtflex_pkg::bin_letter(cur.flush_idx);
                            nxt.flush_idx = cur.flush_idx + 2'd1;
                        end
                        else begin
                            ctl.emit      = 1'b1;
                            tok.kind      = rtflex_pkg::K_LETTER;
                            tok.value     = low;
                            nxt.held      = 2'd0;
                            nxt.flush_idx = 2'd0;
                            nxt.mode      = rtflex_pkg::MODE_WORD;
                            take          = 1'b1;
                        end
                    end
                    else if (b == rtflex_pkg::CH_MINUS) begin
                        nxt.mode = rtflex_pkg::MODE_MINUS;
                        take     = 1'b1;
                    end
                    else if (rtflex_pkg::is_digit(b)) begin
                        nxt.param_neg = 1'b0;
                        nxt.param_sat = 1'b0;
                        accum_next    = PARAM_BITS'(digit);
                        nxt.mode      = rtflex_pkg::MODE_DIGITS;
                        take          = 1'b1;
                    end
                    else if (flushing) begin
                        ctl.emit      = 1'b1;
                        tok.kind      = rtflex_pkg::K_LETTER;
                        tok.value     = rtflex_pkg::bin_letter(cur.flush_idx);
                        nxt.flush_idx = cur.flush_idx + 2'd1;
                    end
                    else begin
                        // Bare word end; a space delimiter is eaten.
                        ctl.emit      = 1'b1;
                        tok.kind      = rtflex_pkg::K_WORD_END;
                        nxt.held      = 2'd0;
                        nxt.flush_idx = 2'd0;
                        nxt.mode      = rtflex_pkg::MODE_IDLE;
                        take          = (b == rtflex_pkg::CH_SPACE);
                    end
                end
                rtflex_pkg::MODE_MINUS:
                begin
                    if (rtflex_pkg::is_digit(b)) begin
                        nxt.param_neg = 1'b1;
                        nxt.param_sat = 1'b0;
                        accum_next    = PARAM_BITS'(digit);
                        nxt.mode      = rtflex_pkg::MODE_DIGITS;
                        take          = 1'b1;
                    end
                    else if (flushing) begin
                        ctl.emit      = 1'b1;
                        tok.kind      = rtflex_pkg::K_LETTER;
                        tok.value     = rtflex_pkg::bin_letter(cur.flush_idx);
                        nxt.flush_idx = cur.flush_idx + 2'd1;
                    end
                    else begin
                        ctl.emit        = 1'b1;
                        tok.kind        = rtflex_pkg::K_WORD_END;
                        nxt.held        = 2'd0;
                        nxt.flush_idx   = 2'd0;
                        nxt.dash_inject = 1'b1;
                        nxt.mode        = rtflex_pkg::MODE_IDLE;
                    end
                end
                rtflex_pkg::MODE_DIGITS:
                begin
                    if (rtflex_pkg::is_digit(b)) begin
                        take = 1'b1;
                        if (prod_over) begin
                            accum_next    = PARAM_BITS'(PARAM_MAX);
                            nxt.param_sat = 1'b1;
                        end
                        else begin
                            accum_next = prod[PARAM_BITS-1:0];
                        end
                    end
                    else if (to_bin) begin
                        // \binN: the next N bytes are raw data.
                        nxt.held      = 2'd0;
                        nxt.flush_idx = 2'd0;
                        nxt.bin_rem   = bin_len;
                        nxt.mode      = rtflex_pkg::MODE_BINDATA;
                        nxt.param_neg = 1'b0;
                        nxt.param_sat = 1'b0;
                        accum_next    = '0;
                        take          = (b == rtflex_pkg::CH_SPACE);
                    end
                    else if (flushing) begin
                        ctl.emit      = 1'b1;
                        tok.kind      = rtflex_pkg::K_LETTER;
                        tok.value     = rtflex_pkg::bin_letter(cur.flush_idx);
                        nxt.flush_idx = cur.flush_idx + 2'd1;
                    end
                    else begin
                        ctl.emit           = 1'b1;
                        tok.kind           = rtflex_pkg::K_WORD_END;
                        tok.has_param      = 1'b1;
                        tok.param_value    = pv32;
                        tok.param_overflow = cur.param_sat;
                        nxt.held           = 2'd0;
                        nxt.flush_idx      = 2'd0;
                        nxt.mode           = rtflex_pkg::MODE_IDLE;
                        nxt.param_neg      = 1'b0;
                        nxt.param_sat      = 1'b0;
                        accum_next         = '0;
                        take               = (b == rtflex_pkg::CH_SPACE);
                    end
                end
                rtflex_pkg::MODE_HEX1:
                begin
                    nxt.hex_high = b;
                    nxt.mode     = rtflex_pkg::MODE_HEX2;
                    take         = 1'b1;
                end
                rtflex_pkg::MODE_HEX2:
                begin
                    ctl.emit = 1'b1;
                    nxt.mode = rtflex_pkg::MODE_IDLE;
                    if (hv_hi[4] && hv_lo[4]) begin
                        tok.kind     = rtflex_pkg::K_HEX;
                        tok.value    = {hv_hi[3:0], hv_lo[3:0]};
                        nxt.hex_high = 8'h00;
                        take         = 1'b1;
                    end
                    else begin
                        // Bad escape: both bytes are lexed again, first one first.
                        tok.kind       = rtflex_pkg::K_SYMBOL;
                        tok.value      = rtflex_pkg::CH_QUOTE;
                        nxt.hex_replay = 1'b1;
                    end
                end
                rtflex_pkg::MODE_BINDATA:
                begin
                    ctl.emit    = 1'b1;
                    tok.kind    = rtflex_pkg::K_BIN;
                    tok.value   = b;
                    nxt.bin_rem = cur.bin_rem - 31'd1;
                    if (cur.bin_rem <= 31'd1) begin
                        nxt.bin_rem = 31'd0;
                        nxt.mode    = rtflex_pkg::MODE_BINEND;
                    end
                    else begin
                        take = 1'b1;
                    end
                end
                default:
                begin
                    nxt.mode = rtflex_pkg::MODE_IDLE;
                    if (cur.text_open) begin
                        ctl.emit = 1'b1;
                        if ((b == rtflex_pkg::CH_LBRACE) || (b == rtflex_pkg::CH_RBRACE)
                            || (b == rtflex_pkg::CH_BSLASH)) begin
                            tok.kind      = rtflex_pkg::K_TEXT_END;
                            nxt.text_open = 1'b0;
                        end
                        else if ((b == rtflex_pkg::CH_CR) || (b == rtflex_pkg::CH_LF)) begin
                            tok.kind      = rtflex_pkg::K_TEXT_END;
                            nxt.text_open = 1'b0;
                            take          = 1'b1;
                        end
                        else begin
                            tok.kind  = rtflex_pkg::K_TEXT;
                            tok.value = b;
                            take      = 1'b1;
                        end
                    end
                    else begin
                        take = 1'b1;
                        if (b == rtflex_pkg::CH_LBRACE) begin
                            ctl.emit = 1'b1;
                            tok.kind = rtflex_pkg::K_GRP_START;
                        end
                        else if (b == rtflex_pkg::CH_RBRACE) begin
                            ctl.emit = 1'b1;
                            tok.kind = rtflex_pkg::K_GRP_END;
                        end
                        else if (b == rtflex_pkg::CH_BSLASH) begin
                            nxt.mode = rtflex_pkg::MODE_ESC;
                        end
                        else if ((b != rtflex_pkg::CH_CR) && (b != rtflex_pkg::CH_LF)) begin
                            ctl.emit      = 1'b1;
                            tok.kind      = rtflex_pkg::K_TEXT;
                            tok.value     = b;
                            nxt.text_open = 1'b1;
                        end
                    end
                end
            endcase
        end

        // A replayed escape byte is used up without taking the input beat.
        ctl.consume = take && !cur.hex_replay;
        if (take && cur.hex_replay) begin
            nxt.hex_replay = 1'b0;
            nxt.hex_high   = 8'h00;
        end
    end

endmodule

### hdl/rtf_token_lexer.sv
// ---------------------------------------------------------------------------
// RTF token lexer
// Splits an RTF byte stream into group, text, control word, symbol, hex
// and binary token elements.
// ---------------------------------------------------------------------------
// A byte beat is taken into an input register and lexed one step of logic
// per cycle while no token waits on token_stall and no final token is held.
// A step yields at most one token, or changes mode silently, as when a
// parameter opens a binary run or a backslash from a bad hex escape is
// replayed. Plain text needs a single step per byte and streams at one byte
// per cycle. A byte needing more steps stays in the input register until
// its last step. If an earlier token of the byte waits, a token of that
// last step goes through a one-token hold register ahead of the output
// register, where its last flag is settled. Bursts reach about six tokens
// on a delimiter that flushes the held letters of b, i, n and replays
// bytes. While a token waits on token_stall, the input register still
// takes one byte beat. There are no memories and no clearing pass.
// ---------------------------------------------------------------------------
module rtf_token_lexer #(
    parameter int PARAM_BITS = rtflex_pkg::PARAM_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    output logic        token_valid,
    input  logic        token_stall,
    output logic [3:0]  kind,
    output logic [7:0]  value,
    output logic        has_param,
    output logic [31:0] param_value,
    output logic        param_overflow,
    output logic        last
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_eod_reg;
    rtflex_pkg::lex_state_t st_reg;
    rtflex_pkg::lex_state_t st_next;
    logic [PARAM_BITS-1:0]  accum_reg;
    logic [PARAM_BITS-1:0]  accum_next;
    rtflex_pkg::token_t     step_tok;
    rtflex_pkg::step_ctl_t  step_ctl;
    logic                   hold_valid_reg;
    logic                   hold_final_reg;
    rtflex_pkg::token_t     hold_tok_reg;
    logic                   out_valid_reg;
    logic                   out_last_reg;
    rtflex_pkg::token_t     out_tok_reg;
    logic                   can_push;
    logic                   run;
    logic                   fire;
    logic                   push;
    logic                   push_last;
    rtflex_pkg::token_t     push_tok;
    logic                   hold_valid_next;
    logic                   hold_final_next;
    logic                   hold_load;

    rtflex_step #(
        .PARAM_BITS (PARAM_BITS)
    ) u_step (
        .cur         (st_reg),
        .accum       (accum_reg),
        .data_byte   (in_byte_reg),
        .end_of_data (in_eod_reg),
        .nxt         (st_next),
        .accum_next  (accum_next),
        .tok         (step_tok),
        .ctl         (step_ctl)
    );

    // Handshake control.
    assign can_push   = !out_valid_reg || !token_stall;
    assign run        = in_valid_reg && can_push && !hold_final_reg;
    assign fire       = run && step_ctl.consume;
    assign byte_stall = in_valid_reg && !fire;

    // Token routing between the step, the hold register and the output.
    always_comb
    begin
        push            = 1'b0;
        push_last       = 1'b0;
        push_tok        = hold_tok_reg;
        hold_valid_next = hold_valid_reg;
        hold_final_next = hold_final_reg;
        hold_load       = 1'b0;
        if (hold_final_reg) begin
            if (can_push) begin
                push            = 1'b1;
                push_last       = 1'b1;
                hold_valid_next = 1'b0;
                hold_final_next = 1'b0;
            end
        end
        else if (run) begin
            if (step_ctl.emit) begin
                if (hold_valid_reg) begin
                    push            = 1'b1;
                    hold_load       = 1'b1;
                    hold_valid_next = 1'b1;
                    hold_final_next = step_ctl.consume;
                end
                else if (step_ctl.consume) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    push_tok  = step_tok;
                end
                else begin
                    hold_load       = 1'b1;
                    hold_valid_next = 1'b1;
                end
            end
            else if (step_ctl.consume && hold_valid_reg) begin
                push            = 1'b1;
                push_last       = 1'b1;
                hold_valid_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            st_reg         <= '{mode: rtflex_pkg::MODE_IDLE, default: '0};
            accum_reg      <= '0;
        end
        else begin
            if (byte_valid && !byte_stall) begin
                in_valid_reg <= 1'b1;
            end
            else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            hold_valid_reg <= hold_valid_next;
            hold_final_reg <= hold_final_next;
            if (push) begin
                out_valid_reg <= 1'b1;
            end
            else if (!token_stall) begin
                out_valid_reg <= 1'b0;
            end
            if (run) begin
                st_reg    <= st_next;
                accum_reg <= accum_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall) begin
            in_byte_reg <= data_byte;
            in_eod_reg  <= end_of_data;
        end
        if (hold_load) begin
            hold_tok_reg <= step_tok;
        end
        if (push) begin
            out_tok_reg  <= push_tok;
            out_last_reg <= push_last;
        end
    end

    assign token_valid    = out_valid_reg;
    assign kind           = out_tok_reg.kind;
    assign value          = out_tok_reg.value;
    assign has_param      = out_tok_reg.has_param;
    assign param_value    = out_tok_reg.param_value;
    assign param_overflow = out_tok_reg.param_overflow;
    assign last           = out_last_reg;

endmodule

### hdl/rtflex_checker.sv
// ---------------------------------------------------------------------------
// RTF lexer port checker
// Watches the ports of the lexer and flags token beats that break the
// rules of the token stream.
// ---------------------------------------------------------------------------
module rtflex_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        token_valid,
    input logic        token_stall,
    input logic [3:0]  kind,
    input logic        has_param,
    input logic [31:0] param_value,
    input logic        param_overflow,
    input logic        last
);

    // A stalled token beat holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(kind) && $stable(last))
        else $error("token beat changed while stalled");

    // Eof is always the last token of its input beat.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (kind == rtflex_pkg::K_EOF) |-> last)
        else $error("eof without last");

    // Only a word end carries a parameter.
    a_param_kind: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (kind != rtflex_pkg::K_WORD_END)
        |-> !has_param && (param_value == 32'd0) && !param_overflow)
        else $error("parameter on a token that is not a word end");

    // Overflow is only flagged on a present parameter.
    a_ovf_param: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && param_overflow |-> has_param)
        else $error("overflow without parameter");

endmodule

bind rtf_token_lexer rtflex_checker u_rtflex_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .token_valid    (token_valid),
    .token_stall    (token_stall),
    .kind           (kind),
    .has_param      (has_param),
    .param_value    (param_value),
    .param_overflow (param_overflow),
    .last           (last)
);
